### sv/psat_pkg.sv
// Package for the preference sorted agent table: payload structs, codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package psat_pkg;
  localparam int TableEntriesDef = 16;
  localparam int MaxReplyDef     = 8;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADV  = 2'd1;
  localparam logic [1:0] MODE_REQ  = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ADDR   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] preference;
    logic [15:0] lifetime_sec;
    logic        mr_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] out_addr_high;
    logic [63:0] out_addr_low;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_FIND, S_INS, S_REQ, S_EMIT, S_WAIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item, clear walk index
    logic tick_op;  // one aging step at current index
    logic find_op;  // one address compare step
    logic ins_op;   // apply insert in one shift
    logic req_op;   // one readout step
    logic emit;     // load output register from pending result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic have_out;  // a result is pending for the output register
    logic out_last;  // pending result is the final one
  } sts_t;
endpackage

### sv/psat_ctrl.sv
// Controller FSM of the agent table. Sequences walks and result transfers.
// Depends on psat_pkg.
`timescale 1ns / 1ps
module psat_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     mode_i,
  input  logic           out_busy_i,
  input  psat_pkg::sts_t sts_i,
  output psat_pkg::cmd_t cmd_o
);
  import psat_pkg::*;
  state_e state_q, state_d;
  logic   ret_req_q, ret_req_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_req_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_req_q <= ret_req_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ret_req_d = ret_req_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_TICK: state_d = S_TICK;
            MODE_ADV:  state_d = S_FIND;
            MODE_REQ:  state_d = S_REQ;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_TICK: if (sts_i.walk_done) state_d = S_IDLE;
      S_FIND: if (sts_i.walk_done) state_d = S_INS;
      S_INS: begin
        ret_req_d = 1'b0;
        state_d   = S_EMIT;
      end
      S_REQ: begin
        ret_req_d = 1'b1;
        if (sts_i.have_out) state_d = S_EMIT;
      end
      S_EMIT: if (!out_busy_i) state_d = sts_i.out_last ? S_WAIT : (ret_req_q ? S_REQ : S_WAIT);
      S_WAIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE:  cmd_o.load    = in_valid_i;
      S_TICK:  cmd_o.tick_op = 1'b1;
      S_FIND:  cmd_o.find_op = 1'b1;
      S_INS:   cmd_o.ins_op  = 1'b1;
      S_REQ:   cmd_o.req_op  = !sts_i.have_out;
      S_EMIT:  cmd_o.emit    = !out_busy_i;
      default: cmd_o         = '0;
    endcase
  end
endmodule

### sv/psat_dp.sv
// Datapath of the agent table: slot registers, walk index, insert shifter, output register.
// Depends on psat_pkg.
`timescale 1ns / 1ps
module psat_dp #(
  parameter int TableEntries = psat_pkg::TableEntriesDef,
  parameter int MaxReply     = psat_pkg::MaxReplyDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psat_pkg::in_item_t  in_data_i,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  input  psat_pkg::cmd_t      cmd_i,
  output psat_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psat_pkg::out_item_t out_data_o
);
  import psat_pkg::*;
  localparam int IW = $clog2(TableEntries + 1);
  localparam int SW = $clog2(TableEntries);
  localparam int RW = $clog2(MaxReply + 1);

  logic [63:0] hi_q [TableEntries];
  logic [63:0] lo_q [TableEntries];
  logic [15:0] pr_q [TableEntries];
  logic [15:0] lt_q [TableEntries];
  logic        cap_q[TableEntries];

  in_item_t  it_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] cnt_q;    // used slots
  logic          found_q;
  logic [SW-1:0] fpos_q;
  logic          fcap_q;
  logic [RW-1:0] rcnt_q;
  logic [3:0]    lim_q;
  out_item_t pend_q;
  logic      pend_v_q;
  out_item_t out_q;
  logic      out_v_q;
  // readout keeps one listed address back so the final one can carry last
  logic [63:0] rd_hi_q;
  logic [63:0] rd_lo_q;
  logic        rd_v_q;

  logic [RW-1:0] limit;
  always_comb begin
    if (lim_q == 4'd0) limit = RW'(1);
    else if (32'(lim_q) > MaxReply) limit = RW'(MaxReply);
    else limit = RW'(lim_q);
  end

  logic [SW-1:0] ix;
  assign ix = idx_q[SW-1:0];
  logic at_end;
  assign at_end = (idx_q >= cnt_q);

  // insert: after optional removal, table t'[k]; pos = first k with pref >= pr
  logic [IW-1:0] n_after;
  logic          full_drop;
  assign n_after   = found_q ? cnt_q - IW'(1) : cnt_q;
  assign full_drop = !found_q && (cnt_q == IW'(TableEntries));

  // compacted view element k: k<fpos -> k, else k+1 (when found)
  function automatic int src_of(int k, logic f, logic [SW-1:0] fp);
    return (f && k >= int'(fp)) ? k + 1 : k;
  endfunction

  logic [TableEntries-1:0] ge;
  logic [IW-1:0] pos;
  always_comb begin
    for (int k = 0; k < TableEntries; k++) begin
      int s;
      s = src_of(k, found_q, fpos_q);
      ge[k] = (k < int'(n_after)) && (s < TableEntries) &&
              (it_q.preference >= pr_q[s < TableEntries ? s : 0]);
    end
    pos = n_after;
    for (int k = TableEntries - 1; k >= 0; k--) if (ge[k]) pos = IW'(k);
  end

  assign sts_o.walk_done = cmd_i.find_op ? (at_end || found_q) : at_end;
  assign sts_o.have_out  = pend_v_q;
  assign sts_o.out_last  = pend_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      rcnt_q   <= '0;
      lim_q    <= 4'd8;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      rd_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) lim_q <= cfg_wdata_i;
      // output register stays full while stalled, refills on emit
      out_v_q <= cmd_i.emit || (out_v_q && out_stall_i);
      if (cmd_i.emit) begin
        out_q    <= pend_q;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.load) begin
        it_q    <= in_data_i;
        idx_q   <= '0;
        found_q <= 1'b0;
        rcnt_q  <= '0;
        rd_v_q  <= 1'b0;
      end
      if (cmd_i.tick_op && !at_end) begin
        if (lt_q[ix] <= 16'd1) begin
          for (int k = 0; k < TableEntries - 1; k++)
            if (k >= int'(ix)) begin
              hi_q[k] <= hi_q[k+1]; lo_q[k] <= lo_q[k+1]; pr_q[k] <= pr_q[k+1];
              lt_q[k] <= lt_q[k+1]; cap_q[k] <= cap_q[k+1];
            end
          cnt_q <= cnt_q - IW'(1);
        end else begin
          lt_q[ix] <= lt_q[ix] - 16'd1;
          idx_q    <= idx_q + IW'(1);
        end
      end
      if (cmd_i.find_op && !at_end && !found_q) begin
        if (hi_q[ix] == it_q.addr_high && lo_q[ix] == it_q.addr_low) begin
          found_q <= 1'b1;
          fpos_q  <= ix;
          fcap_q  <= cap_q[ix];
        end else idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.ins_op) begin
        pend_v_q <= 1'b1;
        pend_q.kind <= KIND_STATUS;
        pend_q.out_addr_high <= it_q.addr_high;
        pend_q.out_addr_low  <= it_q.addr_low;
        pend_q.last <= 1'b1;
        if (full_drop) pend_q.status <= ST_FULL;
        else begin
          pend_q.status <= found_q ? ST_UPDATED : ST_ADDED;
          for (int k = 0; k < TableEntries; k++) begin
            int s;
            s = (k < int'(pos)) ? src_of(k, found_q, fpos_q) : src_of(k - 1, found_q, fpos_q);
            if (k == int'(pos)) begin
              hi_q[k] <= it_q.addr_high; lo_q[k] <= it_q.addr_low;
              pr_q[k] <= it_q.preference; lt_q[k] <= it_q.lifetime_sec;
              cap_q[k] <= found_q ? fcap_q : it_q.mr_flag;
            end else if (k <= int'(n_after) && s >= 0 && s < TableEntries) begin
              hi_q[k] <= hi_q[s]; lo_q[k] <= lo_q[s]; pr_q[k] <= pr_q[s];
              lt_q[k] <= lt_q[s]; cap_q[k] <= cap_q[s];
            end
          end
          if (!found_q) cnt_q <= cnt_q + IW'(1);
        end
      end
      if (cmd_i.req_op) begin
        if (at_end || rcnt_q == limit) begin
          // walk over: flush the held address as final, or report empty
          pend_v_q <= 1'b1;
          rd_v_q   <= 1'b0;
          if (rd_v_q) begin
            pend_q <= '{kind: KIND_ADDR, status: 2'd0, out_addr_high: rd_hi_q,
                        out_addr_low: rd_lo_q, last: 1'b1};
          end else begin
            pend_q <= '{kind: KIND_EMPTY, status: 2'd0, out_addr_high: '0,
                        out_addr_low: '0, last: 1'b1};
          end
        end else begin
          idx_q <= idx_q + IW'(1);
          if (!it_q.mr_flag || cap_q[ix]) begin
            rd_v_q  <= 1'b1;
            rd_hi_q <= hi_q[ix];
            rd_lo_q <= lo_q[ix];
            rcnt_q  <= rcnt_q + RW'(1);
            if (rd_v_q) begin
              pend_v_q <= 1'b1;
              pend_q <= '{kind: KIND_ADDR, status: 2'd0, out_addr_high: rd_hi_q,
                          out_addr_low: rd_lo_q, last: 1'b0};
            end
          end
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule

### sv/preference_sorted_agent_table.sv
// Preference sorted agent table, one item at a time. Advertise: a compare walk over
// the used slots that stops at a match, then insert and emit; the next item is taken
// only after its result has left for the output register. Tick: an aging walk over the
// used slots, no result. Request: a readout walk over the used slots, one reply per
// listed address plus a final flush step; an output stall holds the walk.
// Reset empties the table and sets reply_limit to 8. Depends on psat_pkg, psat_ctrl, psat_dp.
`timescale 1ns / 1ps
module preference_sorted_agent_table #(
  parameter int TableEntries = psat_pkg::TableEntriesDef,
  parameter int MaxReply     = psat_pkg::MaxReplyDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psat_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psat_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i
);
  import psat_pkg::*;
  cmd_t cmd;
  sts_t sts;
  // controller sees the output stage busy while the output register holds a stalled result
  psat_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .mode_i(in_data_i.mode), .out_busy_i(out_valid_o && out_stall_i),
    .sts_i(sts), .cmd_o(cmd)
  );
  psat_dp #(.TableEntries(TableEntries), .MaxReply(MaxReply)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_i(cmd), .sts_o(sts), .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

### sv/psat_checker.sv
// Port-level checks for the agent table, bound to the top level.
// Depends on psat_pkg.
`timescale 1ns / 1ps
module psat_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input psat_pkg::out_item_t out_data_o
);
  import psat_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("payload moved");
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("valid dropped");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind != 2'd3) else $error("bad kind");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_EMPTY |-> out_data_o.last)
    else $error("empty not last");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_STATUS |-> out_data_o.last)
    else $error("status not last");
endmodule

bind preference_sorted_agent_table psat_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o
);

### bench/tb_preference_sorted_agent_table.sv
// Testbench for preference_sorted_agent_table: directed table then random traffic,
// checked against an in-bench model of the sorted agent table. Depends on psat_pkg.
`timescale 1ns / 1ps
module tb_preference_sorted_agent_table;
  import psat_pkg::*;

  localparam int NumSlots  = 16;
  localparam int ReplyCap  = 8;
  localparam int DogLimit  = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;
  logic      cfg_we_i;
  logic [3:0] cfg_wdata_i;

  preference_sorted_agent_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the agent table, kept packed from slot 0 in preference order.
  int          tbl_used;
  logic [63:0] tbl_hi   [NumSlots+1];
  logic [63:0] tbl_lo   [NumSlots+1];
  logic [15:0] tbl_pref [NumSlots+1];
  logic [15:0] tbl_life [NumSlots+1];
  logic        tbl_cap  [NumSlots+1];
  logic [3:0]  limit_reg;

  out_item_t pending_replies[$];
  int        errors;
  int        n_sent, n_results, n_full, n_upd, n_empty;
  bit        quiet;          // no idling in the tail of the run
  bit        long_hold_req;  // receiver should hold off for a long stretch
  bit        long_hold_done; // receiver has done its long hold-off
  int        dog = 0;

  function automatic out_item_t mk(logic [1:0] k, logic [1:0] s, logic [63:0] h,
                                   logic [63:0] l, logic lst);
    out_item_t o;
    o.kind = k; o.status = s; o.out_addr_high = h; o.out_addr_low = l; o.last = lst;
    return o;
  endfunction

  function automatic void drop_slot(int p);
    for (int k = p; k + 1 < tbl_used; k++) begin
      tbl_hi[k] = tbl_hi[k+1]; tbl_lo[k] = tbl_lo[k+1];
      tbl_pref[k] = tbl_pref[k+1]; tbl_life[k] = tbl_life[k+1];
      tbl_cap[k] = tbl_cap[k+1];
    end
    tbl_used--;
  endfunction

  // Works out the results of one transfer and updates the shadow table.
  function automatic void predict_table(in_item_t it);
    int k, pos, cnt, lim;
    bit found;
    logic cap;
    found = 0; cap = it.mr_flag; cnt = 0;
    case (it.mode)
      MODE_TICK: begin
        k = 0;
        while (k < tbl_used) begin
          if (tbl_life[k] <= 1) drop_slot(k);
          else begin
            tbl_life[k]--; k++;
          end
        end
      end
      MODE_ADV: begin
        for (k = 0; k < tbl_used; k++) begin
          if (tbl_hi[k] == it.addr_high && tbl_lo[k] == it.addr_low) begin
            found = 1; cap = tbl_cap[k]; drop_slot(k); break;
          end
        end
        if (!found && tbl_used >= NumSlots) begin
          pending_replies.push_back(mk(KIND_STATUS, ST_FULL, it.addr_high, it.addr_low, 1'b1));
        end else begin
          pos = tbl_used;
          for (k = 0; k < tbl_used; k++) begin
            if (it.preference >= tbl_pref[k]) begin
              pos = k; break;
            end
          end
          for (k = tbl_used; k > pos; k--) begin
            tbl_hi[k] = tbl_hi[k-1]; tbl_lo[k] = tbl_lo[k-1];
            tbl_pref[k] = tbl_pref[k-1]; tbl_life[k] = tbl_life[k-1];
            tbl_cap[k] = tbl_cap[k-1];
          end
          tbl_hi[pos] = it.addr_high; tbl_lo[pos] = it.addr_low;
          tbl_pref[pos] = it.preference; tbl_life[pos] = it.lifetime_sec;
          tbl_cap[pos] = cap;
          tbl_used++;
          pending_replies.push_back(mk(KIND_STATUS, found ? ST_UPDATED : ST_ADDED,
                                       it.addr_high, it.addr_low, 1'b1));
        end
      end
      MODE_REQ: begin
        lim = (limit_reg == 0) ? 1 : (limit_reg > ReplyCap ? ReplyCap : limit_reg);
        for (k = 0; k < tbl_used && cnt < lim; k++) begin
          if (!it.mr_flag || tbl_cap[k]) begin
            pending_replies.push_back(mk(KIND_ADDR, ST_ADDED, tbl_hi[k], tbl_lo[k], 1'b0));
            cnt++;
          end
        end
        if (cnt == 0) pending_replies.push_back(mk(KIND_EMPTY, ST_ADDED, '0, '0, 1'b1));
        else pending_replies[$].last = 1'b1;
      end
      default: ;  // unused mode is ignored
    endcase
  endfunction

  // Output side: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        out_item_t e;
        e = pending_replies.pop_front();
        if (out_data_o.kind == KIND_STATUS && out_data_o.status == ST_FULL) n_full++;
        if (out_data_o.kind == KIND_STATUS && out_data_o.status == ST_UPDATED) n_upd++;
        if (out_data_o.kind == KIND_EMPTY) n_empty++;
        if (out_data_o.kind !== e.kind || out_data_o.status !== e.status ||
            out_data_o.out_addr_high !== e.out_addr_high ||
            out_data_o.out_addr_low !== e.out_addr_low || out_data_o.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random bursts, one long hold-off when asked.
  initial begin
    int burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_done = 1;
        @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_replies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drives one item and waits for its transfer; optional idle gap first.
  task automatic send_item(in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_table(it);
    n_sent++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    // ticks give no result; let the last walk finish
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [3:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_reg = v;
  endtask

  function automatic in_item_t make_item(logic [1:0] m, logic [63:0] h, logic [63:0] l,
                                         logic [15:0] p, logic [15:0] t, logic f);
    in_item_t it;
    it.mode = m; it.addr_high = h; it.addr_low = l;
    it.preference = p; it.lifetime_sec = t; it.mr_flag = f;
    return it;
  endfunction

  // Random advertise drawn from a small address pool so updates are frequent;
  // now and then a fully random address for bit coverage.
  function automatic in_item_t rand_adv();
    logic [63:0] h, l;
    logic [15:0] p, t;
    if ($urandom_range(0, 4) == 0) begin
      h = {$urandom, $urandom}; l = {$urandom, $urandom};
    end else begin
      h = 64'hA5A5_0000_0000_0000 | $urandom_range(0, 3);
      l = {$urandom_range(0, 7), 32'h0000_0000} | $urandom_range(0, 3);
    end
    p = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    t = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    return make_item(MODE_ADV, h, l, p, t, 1'($urandom));
  endfunction

  typedef struct {
    in_item_t  stim;
    bit        has_gold;  // expected result typed in here
    out_item_t gold;
  } vec_row_t;

  vec_row_t  vec_rows[$];
  in_item_t  it;
  int        r;

  initial begin
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    errors = 0; n_sent = 0; n_results = 0; n_full = 0; n_upd = 0; n_empty = 0;
    quiet = 0; long_hold_req = 0;
    tbl_used = 0; limit_reg = 4'd8;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Rows with gold carry a result readable by inspection;
    // the rest go through the predictor.
    vec_rows.push_back('{make_item(MODE_REQ, '0, '0, 0, 0, 0), 1,
                         mk(KIND_EMPTY, ST_ADDED, '0, '0, 1)});          // empty after reset
    vec_rows.push_back('{make_item(MODE_TICK, '0, '0, 0, 0, 0), 0, '0}); // tick on empty table
    vec_rows.push_back('{make_item(MODE_ADV, '1, '1, 16'hFFFF, 16'hFFFF, 1), 1,
                         mk(KIND_STATUS, ST_ADDED, '1, '1, 1)});         // all-ones extreme
    vec_rows.push_back('{make_item(MODE_ADV, '0, '0, 0, 0, 0), 1,
                         mk(KIND_STATUS, ST_ADDED, '0, '0, 1)});         // zero lifetime entry
    vec_rows.push_back('{make_item(MODE_ADV, 64'h1, 64'h2, 16'd5, 16'd3, 1), 0, '0});
    vec_rows.push_back('{make_item(MODE_ADV, 64'h3, 64'h4, 16'd5, 16'd2, 0), 0, '0}); // tie
    vec_rows.push_back('{make_item(MODE_ADV, 64'h1, 64'h2, 16'd5, 16'd9, 0), 1,
                         mk(KIND_STATUS, ST_UPDATED, 64'h1, 64'h2, 1)}); // keeps capable
    vec_rows.push_back('{make_item(2'd3, '1, '1, '1, '1, 1), 0, '0});     // unused mode
    vec_rows.push_back('{make_item(MODE_REQ, '0, '0, 0, 0, 0), 0, '0});
    vec_rows.push_back('{make_item(MODE_REQ, '0, '0, 0, 0, 1), 0, '0});  // capable only
    vec_rows.push_back('{make_item(MODE_TICK, '0, '0, 0, 0, 0), 0, '0}); // drops zero life
    vec_rows.push_back('{make_item(MODE_REQ, '0, '0, 0, 0, 0), 0, '0});
    for (r = 0; r < vec_rows.size(); r++) begin
      if (vec_rows[r].has_gold) begin
        send_item(vec_rows[r].stim);
        if (pending_replies.size() == 0 || pending_replies[$] != vec_rows[r].gold) begin
          $display("%0t: directed row %0d expected %p", $time, r, vec_rows[r].gold);
          errors++;
        end
      end else begin
        send_item(vec_rows[r].stim);
      end
    end

    // Fill the table past full, then update a known address while full.
    go_idle();
    write_limit(4'd0);  // acts as one
    for (r = 0; r < 17; r++)
      send_item(make_item(MODE_ADV, 64'hF00 + r, 64'(r), 16'(r % 4), 16'd4, 1'(r)));
    send_item(make_item(MODE_ADV, 64'hF00, 64'd0, 16'd9, 16'd4, 0));
    send_item(make_item(MODE_REQ, '0, '0, 0, 0, 0));
    go_idle();
    write_limit(4'd15);  // clamps to eight
    send_item(make_item(MODE_REQ, '0, '0, 0, 0, 0));
    send_item(make_item(MODE_REQ, '0, '0, 0, 0, 1));
    // Receiver holds off while requests keep arriving, so the block backs up.
    long_hold_req = 1;
    for (r = 0; r < 6; r++) send_item(make_item(MODE_REQ, '0, '0, 0, 0, 1'(r)));
    repeat (4) send_item(make_item(MODE_TICK, '0, '0, 0, 0, 0));

    // Random phases over several limit settings; the last one runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      go_idle();
      write_limit(ph == 4 ? 4'd8 : (ph == 0 ? 4'd1 : 4'($urandom_range(0, 15))));
      if (ph == 4) quiet = 1;
      for (r = 0; r < 22; r++) begin
        case ($urandom_range(0, 9))
          0, 1:    it = make_item(MODE_TICK, {$urandom, $urandom}, '0, 0, 0, 1'($urandom));
          2, 3:    it = make_item(MODE_REQ, {$urandom, $urandom}, {$urandom, $urandom},
                                  16'($urandom), 16'($urandom), 1'($urandom));
          4:       it = make_item(2'd3, '0, '0, 0, 0, 0);
          default: it = rand_adv();
        endcase
        send_item(it);
      end
    end

    in_valid_i <= 1'b0;
    for (int w = 0; w < 50000 && pending_replies.size() != 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results (%0d updates, %0d table-full drops,",
             n_sent, n_results, n_upd, n_full);
    $display("  %0d empty replies) across reply limits 0, 1, 8, 15 and random.", n_empty);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, pending_replies.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### files.f
sv/psat_pkg.sv
sv/psat_ctrl.sv
sv/psat_dp.sv
sv/preference_sorted_agent_table.sv
sv/psat_checker.sv
bench/tb_preference_sorted_agent_table.sv
